// File: design/prs_pkg.sv
// ----------------------------------------------------------------------------
// prs_pkg
// Shared types and constants for the multiplicative persistence search:
// payload structs, sizes of the digit-serial datapath and the control states.
// ----------------------------------------------------------------------------
package prs_pkg;

    // number width used by the datapath, 8 to 64
    localparam int NUMBER_WIDTH = 64;
    localparam int CAND_WIDTH   = 64;
    localparam int LEVEL_WIDTH  = 4;

    // decimal digits needed for a NUMBER_WIDTH-bit value (log10(2) ~ 0.30103)
    localparam int DIGITS       = (NUMBER_WIDTH * 30103) / 100000 + 1;
    localparam int BCD_WIDTH    = DIGITS * 4;

    // binary to bcd conversion takes STEP_BITS bits per cycle
    localparam int STEP_BITS    = 4;
    localparam int DABBLE_STEPS = (NUMBER_WIDTH + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_WIDTH    = DABBLE_STEPS * STEP_BITS;

    localparam int BCD_CNT_W    = (DABBLE_STEPS > 1) ? $clog2(DABBLE_STEPS) : 1;
    localparam int PROD_CNT_W   = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    localparam logic [NUMBER_WIDTH-1:0] SINGLE_DIGIT_MAX = NUMBER_WIDTH'(9);
    localparam logic [LEVEL_WIDTH-1:0]  LEVEL_MAX        = LEVEL_WIDTH'(15);

    typedef logic [NUMBER_WIDTH-1:0] num_t;
    typedef logic [BCD_WIDTH-1:0]    bcd_t;

    typedef struct packed {
        logic [CAND_WIDTH-1:0] candidate;
        logic                  start_search;
        logic                  range_end;
    } item_t;

    typedef struct packed {
        logic [LEVEL_WIDTH-1:0] level;
        logic [CAND_WIDTH-1:0]  best_value;
        logic [LEVEL_WIDTH-1:0] best_rounds;
        logic                   search_done;
    } result_t;

    // status of the conversion unit
    typedef struct packed {
        logic done;
        bcd_t digits;
    } bcd_stat_t;

    // status of the digit product unit
    typedef struct packed {
        logic done;
        num_t product;
    } prod_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_BCD,
        ST_PROD,
        ST_FINISH
    } state_t;

endpackage

// File: design/prs_bcd.sv
// ----------------------------------------------------------------------------
// prs_bcd
// Binary to packed bcd conversion by shift and add-3, four bits per cycle,
// most significant bits first.
// ----------------------------------------------------------------------------
module prs_bcd (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  prs_pkg::num_t      value,
    output prs_pkg::bcd_stat_t stat
);

    logic [prs_pkg::PAD_WIDTH-1:0] shift_reg;
    logic [prs_pkg::PAD_WIDTH-1:0] shift_next;
    prs_pkg::bcd_t                 bcd_reg;
    prs_pkg::bcd_t                 bcd_next;
    logic [prs_pkg::BCD_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic                          last_step;

    assign last_step = (cnt_reg == prs_pkg::BCD_CNT_W'(prs_pkg::DABBLE_STEPS - 1));

    // four dependent shift steps, each digit corrected independently
    always_comb
    begin
        bcd_next   = bcd_reg;
        shift_next = shift_reg;
        for (int s = 0; s < prs_pkg::STEP_BITS; s++)
        begin
            for (int d = 0; d < prs_pkg::DIGITS; d++)
            begin
                if (bcd_next[d*4 +: 4] >= 4'd5)
                begin
                    bcd_next[d*4 +: 4] = bcd_next[d*4 +: 4] + 4'd3;
                end
            end
            bcd_next   = {bcd_next[prs_pkg::BCD_WIDTH-2:0], shift_next[prs_pkg::PAD_WIDTH-1]};
            shift_next = {shift_next[prs_pkg::PAD_WIDTH-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= prs_pkg::PAD_WIDTH'(value);
            bcd_reg   <= '0;
        end
        else if (busy_reg)
        begin
            shift_reg <= shift_next;
            bcd_reg   <= bcd_next;
        end
    end

    assign stat.done   = done_reg;
    assign stat.digits = bcd_reg;

endmodule

// File: design/prs_dprod.sv
// ----------------------------------------------------------------------------
// prs_dprod
// Product of decimal digits, one digit per cycle from the most significant,
// with leading zeros skipped.
// ----------------------------------------------------------------------------
module prs_dprod (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  prs_pkg::bcd_t       digits,
    output prs_pkg::prod_stat_t stat
);

    prs_pkg::bcd_t                    dig_reg;
    prs_pkg::num_t                    prod_reg;
    prs_pkg::num_t                    prod_next;
    logic                             seen_reg;
    logic [prs_pkg::PROD_CNT_W-1:0]   cnt_reg;
    logic                             busy_reg;
    logic                             done_reg;
    logic [3:0]                       digit;
    logic [prs_pkg::NUMBER_WIDTH+3:0] prod_full;
    logic                             use_digit;
    logic                             last_digit;

    assign digit      = dig_reg[prs_pkg::BCD_WIDTH-1 -: 4];
    assign use_digit  = seen_reg || (digit != 4'd0);
    assign last_digit = (cnt_reg == prs_pkg::PROD_CNT_W'(prs_pkg::DIGITS - 1));

    // product of digits never exceeds the number, so truncation loses nothing
    assign prod_full = {4'b0, prod_reg} * {{prs_pkg::NUMBER_WIDTH{1'b0}}, digit};
    assign prod_next = use_digit ? prod_full[prs_pkg::NUMBER_WIDTH-1:0] : prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_digit)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dig_reg  <= digits;
            prod_reg <= prs_pkg::NUMBER_WIDTH'(1);
            seen_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            dig_reg  <= {dig_reg[prs_pkg::BCD_WIDTH-5:0], 4'b0};
            prod_reg <= prod_next;
            seen_reg <= use_digit;
        end
    end

    assign stat.done    = done_reg;
    assign stat.product = prod_reg;

endmodule

// File: design/persistence_range_search_top.sv
// ----------------------------------------------------------------------------
// persistence_range_search_top
// Multiplicative persistence of each candidate and a running search for the
// first candidate of the highest persistence.
//
//   channel | valid      | stall      | payload
//   --------+------------+------------+--------------------------
//   input   | item_valid | item_stall | item_data  (prs_pkg::item_t)
//   output  | res_valid  | res_stall  | res_data   (prs_pkg::result_t)
//
// one item at a time; each round of digit product runs the 4-bit-per-cycle
// bcd converter and then the one-digit-per-cycle multiplier; a result is
// loaded in the finishing state after the last round, and the next item is
// taken in the idle state that follows at the earliest
// a new item is taken while the previous result still waits in the output
// register; a stalled result holds the finished item in the last state
// reset clears the kept best and all control state
// ----------------------------------------------------------------------------
module persistence_range_search_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  prs_pkg::item_t   item_data,
    output logic             res_valid,
    input  logic             res_stall,
    output prs_pkg::result_t res_data
);

    prs_pkg::state_t                 state_reg;
    prs_pkg::state_t                 state_next;

    prs_pkg::num_t                   val_reg;
    prs_pkg::num_t                   cand_reg;
    logic                            start_reg;
    logic                            end_reg;
    logic [prs_pkg::LEVEL_WIDTH-1:0] rounds_reg;

    prs_pkg::num_t                   kept_number_reg;
    logic [prs_pkg::LEVEL_WIDTH-1:0] kept_level_reg;
    logic                            kept_valid_reg;

    logic                            res_valid_reg;
    prs_pkg::result_t                res_reg;

    logic                            accept;
    logic                            bcd_start;
    logic                            prod_start;
    logic                            load_result;
    logic                            more_rounds;
    logic                            take_best;
    prs_pkg::bcd_stat_t              bcd_stat;
    prs_pkg::prod_stat_t             prod_stat;

    prs_bcd u_bcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (bcd_start),
        .value (val_reg),
        .stat  (bcd_stat)
    );

    prs_dprod u_dprod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (prod_start),
        .digits (bcd_stat.digits),
        .stat   (prod_stat)
    );

    assign accept      = item_valid && !item_stall;
    assign more_rounds = (val_reg > prs_pkg::SINGLE_DIGIT_MAX);
    assign take_best   = start_reg || !kept_valid_reg || (rounds_reg > kept_level_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            prs_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = prs_pkg::ST_CHECK;
                end
            end
            prs_pkg::ST_CHECK:
            begin
                state_next = more_rounds ? prs_pkg::ST_BCD : prs_pkg::ST_FINISH;
            end
            prs_pkg::ST_BCD:
            begin
                if (bcd_stat.done)
                begin
                    state_next = prs_pkg::ST_PROD;
                end
            end
            prs_pkg::ST_PROD:
            begin
                if (prod_stat.done)
                begin
                    state_next = prs_pkg::ST_CHECK;
                end
            end
            prs_pkg::ST_FINISH:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    state_next = prs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = prs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_stall  = 1'b1;
        bcd_start   = 1'b0;
        prod_start  = 1'b0;
        load_result = 1'b0;
        case (state_reg)
            prs_pkg::ST_IDLE:   item_stall  = 1'b0;
            prs_pkg::ST_CHECK:  bcd_start   = more_rounds;
            prs_pkg::ST_BCD:    prod_start  = bcd_stat.done;
            prs_pkg::ST_PROD:   ;
            prs_pkg::ST_FINISH: load_result = !res_valid_reg || !res_stall;
            default:            ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= prs_pkg::ST_IDLE;
            kept_number_reg <= '0;
            kept_level_reg  <= '0;
            kept_valid_reg  <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_result)
            begin
                res_valid_reg <= 1'b1;
                if (take_best)
                begin
                    kept_number_reg <= cand_reg;
                    kept_level_reg  <= rounds_reg;
                    kept_valid_reg  <= 1'b1;
                end
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            val_reg    <= item_data.candidate[prs_pkg::NUMBER_WIDTH-1:0];
            cand_reg   <= item_data.candidate[prs_pkg::NUMBER_WIDTH-1:0];
            start_reg  <= item_data.start_search;
            end_reg    <= item_data.range_end;
            rounds_reg <= '0;
        end
        else
        begin
            if (bcd_start && (rounds_reg != prs_pkg::LEVEL_MAX))
            begin
                rounds_reg <= rounds_reg + 1'b1;
            end
            if (state_reg == prs_pkg::ST_PROD && prod_stat.done)
            begin
                val_reg <= prod_stat.product;
            end
        end
        if (load_result)
        begin
            res_reg.level       <= rounds_reg;
            res_reg.best_value  <= prs_pkg::CAND_WIDTH'(take_best ? cand_reg : kept_number_reg);
            res_reg.best_rounds <= take_best ? rounds_reg : kept_level_reg;
            res_reg.search_done <= end_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

endmodule

// File: design/prs_checker.sv
// ----------------------------------------------------------------------------
// prs_checker
// Port-level checks of the persistence search, bound to the top level.
// ----------------------------------------------------------------------------
module prs_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_stall,
    input logic             res_valid,
    input logic             res_stall,
    input prs_pkg::result_t res_data
);

    // a stalled result stays put
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=> (res_valid && $stable(res_data)))
        else $error("result changed while stalled");

    // the kept best includes the current item, so it is never below it
    a_best_max: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_data.best_rounds >= res_data.level))
        else $error("best level below item level");

    // one item at a time: busy right after an item is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> item_stall)
        else $error("second item taken while busy");

    // a result appears only from the finishing step, never from idle
    a_res_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(item_stall))
        else $error("result appeared without an item in flight");

endmodule

bind persistence_range_search_top prs_checker u_prs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_data   (res_data)
);
